/* sv/json_string_unescape_unit_macros.svh */
`ifndef JSON_STRING_UNESCAPE_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UNIT_MACROS_SVH

// check in the same cycle
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// check in the following cycle
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/jsu_pkg.sv */
package jsu_pkg;

    localparam int unsigned CP_W = 21;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            text_ended;
    } t_in_word;

    typedef struct packed {
        logic [CP_W-1:0] out_char;
        logic            char_valid;
        logic            last;
        logic            error;
    } t_out_word;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'b001,
        MODE_ESC   = 3'b010,
        MODE_HEX   = 3'b100
    } t_mode;

    localparam logic [CP_W-1:0] CH_QUOTE  = 21'h00_0022;
    localparam logic [CP_W-1:0] CH_BSLASH = 21'h00_005C;
    localparam logic [CP_W-1:0] CH_SLASH  = 21'h00_002F;
    localparam logic [CP_W-1:0] CH_B      = 21'h00_0062;
    localparam logic [CP_W-1:0] CH_F      = 21'h00_0066;
    localparam logic [CP_W-1:0] CH_N      = 21'h00_006E;
    localparam logic [CP_W-1:0] CH_R      = 21'h00_0072;
    localparam logic [CP_W-1:0] CH_T      = 21'h00_0074;
    localparam logic [CP_W-1:0] CH_U      = 21'h00_0075;
    localparam logic [CP_W-1:0] CH_BS     = 21'h00_0008;
    localparam logic [CP_W-1:0] CH_FF     = 21'h00_000C;
    localparam logic [CP_W-1:0] CH_LF     = 21'h00_000A;
    localparam logic [CP_W-1:0] CH_CR     = 21'h00_000D;
    localparam logic [CP_W-1:0] CH_TAB    = 21'h00_0009;
    localparam logic [CP_W-1:0] CH_SPACE  = 21'h00_0020;

    localparam logic [10:0] HI_SURR_TOP = 11'h036;  // 0xD800 >> 10
    localparam logic [5:0]  LO_SURR_TOP = 6'h37;    // 0xDC00 >> 10
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h01_0000;

    localparam logic [1:0] HEX_LAST = 2'd3;

endpackage

/* sv/jsu_in_stage.sv */
module jsu_in_stage import jsu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_word,
    output logic     o_valid,
    input  logic     i_down_ready,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_down_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_down_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

/* sv/jsu_decode.sv */
`include "json_string_unescape_unit_macros.svh"

module jsu_decode import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    output logic      o_res_valid,
    output t_out_word o_res
);

    t_mode            r_mode, n_mode;
    logic [1:0]       r_hex_count, n_hex_count;
    logic [15:0]      r_hex_accum, n_hex_accum;
    logic [CP_W-1:0]  r_held_char, n_held_char;
    logic             r_held_valid, n_held_valid;

    logic [CP_W-1:0]  c;
    logic [3:0]       digit;
    logic             digit_ok;
    logic [15:0]      hex_val;
    logic             do_push, do_fail, do_close;
    logic [CP_W-1:0]  push_val;
    logic             merge;
    logic [CP_W-1:0]  merged;

    assign c       = i_word.code_point;
    assign hex_val = {r_hex_accum[11:0], digit};
    assign merge   = (hex_val[15:10] == LO_SURR_TOP) && r_held_valid
                     && (r_held_char[20:10] == HI_SURR_TOP);
    assign merged  = {1'b0, r_held_char[9:0], hex_val[9:0]} + SUPP_BASE;

    always_comb begin
        digit    = 4'd0;
        digit_ok = 1'b0;
        if (c >= 21'h30 && c <= 21'h39) begin
            digit    = c[3:0];
            digit_ok = 1'b1;
        end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
            digit    = c[3:0] + 4'd9;
            digit_ok = 1'b1;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_hex_count  = r_hex_count;
        n_hex_accum  = r_hex_accum;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        do_push      = 1'b0;
        do_fail      = 1'b0;
        do_close     = 1'b0;
        push_val     = c;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (i_word.text_ended) begin
            do_fail = 1'b1;
        end else begin
            unique case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_PLAIN;
                    unique case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: do_push = 1'b1;
                        CH_B: begin
                            do_push  = 1'b1;
                            push_val = CH_BS;
                        end
                        CH_F: begin
                            do_push  = 1'b1;
                            push_val = CH_FF;
                        end
                        CH_N: begin
                            do_push  = 1'b1;
                            push_val = CH_LF;
                        end
                        CH_R: begin
                            do_push  = 1'b1;
                            push_val = CH_CR;
                        end
                        CH_T: begin
                            do_push  = 1'b1;
                            push_val = CH_TAB;
                        end
                        CH_U: begin
                            n_mode      = MODE_HEX;
                            n_hex_count = 2'd0;
                            n_hex_accum = 16'd0;
                        end
                        default: do_fail = 1'b1;
                    endcase
                end
                MODE_HEX: begin
                    if (!digit_ok) begin
                        do_fail = 1'b1;
                    end else if (r_hex_count != HEX_LAST) begin
                        n_hex_accum = hex_val;
                        n_hex_count = r_hex_count + 2'd1;
                    end else begin
                        n_mode      = MODE_PLAIN;
                        n_hex_count = 2'd0;
                        n_hex_accum = 16'd0;
                        if (merge) begin
                            n_held_char = merged;
                        end else begin
                            do_push  = 1'b1;
                            push_val = {5'd0, hex_val};
                        end
                    end
                end
                default: begin
                    if (c == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else if (c == CH_QUOTE) begin
                        do_close = 1'b1;
                    end else if (c < CH_SPACE) begin
                        do_fail = 1'b1;
                    end else begin
                        n_mode  = MODE_PLAIN;
                        do_push = 1'b1;
                    end
                end
            endcase
        end

        if (do_push) begin
            if (r_held_valid) begin
                o_res_valid      = 1'b1;
                o_res.out_char   = r_held_char;
                o_res.char_valid = 1'b1;
            end
            n_held_char  = push_val;
            n_held_valid = 1'b1;
        end

        if (do_fail || do_close) begin
            o_res_valid = 1'b1;
            o_res.last  = 1'b1;
            o_res.error = do_fail;
            if (do_close && r_held_valid) begin
                o_res.out_char   = r_held_char;
                o_res.char_valid = 1'b1;
            end
            n_mode       = MODE_PLAIN;
            n_hex_count  = 2'd0;
            n_hex_accum  = 16'd0;
            n_held_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_PLAIN;
            r_hex_count  <= 2'd0;
            r_hex_accum  <= 16'd0;
            r_held_valid <= 1'b0;
        end else if (i_fire) begin
            r_mode       <= n_mode;
            r_hex_count  <= n_hex_count;
            r_hex_accum  <= n_hex_accum;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_held_char <= n_held_char;
        end
    end

    `JSU_ASSERT_NEXT(a_last_clears, i_fire && o_res_valid && o_res.last,
        r_mode == MODE_PLAIN && !r_held_valid && r_hex_count == 2'd0,
        "state not cleared after final word")
    `JSU_ASSERT_NOW(a_count_in_hex, r_mode != MODE_HEX, r_hex_count == 2'd0,
        "hex count set outside hex mode")
    `JSU_ASSERT_NOW(a_mid_needs_held, i_fire && o_res_valid && !o_res.last,
        o_res.char_valid && r_held_valid && !o_res.error,
        "mid-string word without held character")

endmodule

/* sv/jsu_out_stage.sv */
module jsu_out_stage import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  logic      i_res_valid,
    input  t_out_word i_res,
    output logic      o_up_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic      r_valid;
    t_out_word r_word;

    assign o_up_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_word <= i_res;
        end
    end

endmodule

/* sv/json_string_unescape_unit.sv */
// JSON string body unescaper.
// Input channel (i_valid / o_ready, i_in_word): one code point of the string
// body per word, starting after the opening quote, or text_ended to abort.
// Output channel (o_valid / i_ready, o_out_word): decoded characters, one
// word behind the input so a \u low surrogate can merge into the held high
// surrogate. The closing quote flushes the held character with last set;
// malformed text gives one word with error and last set.
// An input word is registered at acceptance, decoded combinationally, and its
// result is loaded into the output register once that register is free or
// draining. Throughput: one word per cycle while i_ready does not stall the
// output. Words that produce no result (backslash, hex digits, merges)
// leave a bubble.
// Reset: synchronous active-low i_rst_n empties both registers and returns
// the decoder to plain mode with nothing held.
// Stall: with i_ready low, the output register holds its word; the input
// register fills and o_ready drops until the output drains.
module json_string_unescape_unit import jsu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_in_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_out_word
);

    logic      in_valid;
    t_in_word  in_word;
    logic      up_ready;
    logic      fire;
    logic      res_valid;
    t_out_word res;

    assign fire = in_valid && up_ready;

    jsu_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_word       (i_in_word),
        .o_valid      (in_valid),
        .i_down_ready (up_ready),
        .o_word       (in_word)
    );

    jsu_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_word      (in_word),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jsu_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_up_ready  (up_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_out_word)
    );

endmodule

/* dv/json_string_unescape_unit_tb.sv */
module json_string_unescape_unit_tb;
    import jsu_pkg::*;

    localparam logic [CP_W-1:0] DIG_0  = 21'h00_0030;
    localparam logic [CP_W-1:0] DIG_9  = 21'h00_0039;
    localparam logic [CP_W-1:0] HEX_UA = 21'h00_0041;
    localparam logic [CP_W-1:0] HEX_UF = 21'h00_0046;
    localparam logic [CP_W-1:0] HEX_LA = 21'h00_0061;
    localparam logic [CP_W-1:0] HEX_LF = 21'h00_0066;
    localparam logic [CP_W-1:0] CH_X   = 21'h00_0078;

    localparam int unsigned RANDOM_WORDS = 500;
    localparam int unsigned IDLE_PCT     = 34;

    typedef struct packed {
        t_in_word  stim;
        bit        typed;
        t_out_word want;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_in_word;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_out_word;

    json_string_unescape_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_word  (i_in_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_word (o_out_word)
    );

    t_mode           dec_mode;
    logic [1:0]      hex_cnt;
    logic [15:0]     hex_acc;
    logic [CP_W-1:0] held_cp;
    logic            held_ok;

    t_out_word   chars_due[$];
    t_in_word    str_q[$];
    t_dir_row    dir_rows[$];
    int unsigned bad_words;
    int unsigned words_sent;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void clear_decoder();
        dec_mode = MODE_PLAIN;
        hex_cnt  = '0;
        hex_acc  = '0;
        held_cp  = '0;
        held_ok  = 1'b0;
    endfunction

    function automatic t_out_word abort_string();
        t_out_word r;
        r       = '0;
        r.last  = 1'b1;
        r.error = 1'b1;
        clear_decoder();
        return r;
    endfunction

    function automatic int hex_nibble(input logic [CP_W-1:0] c);
        if (c >= DIG_0 && c <= DIG_9) return int'(c - DIG_0);
        if (c >= HEX_UA && c <= HEX_UF) return int'(c - HEX_UA) + 10;
        if (c >= HEX_LA && c <= HEX_LF) return int'(c - HEX_LA) + 10;
        return -1;
    endfunction

    // emit the held character, then hold c
    function automatic void hold_char(input logic [CP_W-1:0] c, output bit has,
                                      output t_out_word r);
        r            = '0;
        has          = held_ok;
        r.out_char   = held_ok ? held_cp : '0;
        r.char_valid = held_ok;
        held_cp      = c;
        held_ok      = 1'b1;
    endfunction

    function automatic void decode_char(input t_in_word w, output bit has,
                                        output t_out_word r);
        int          nib;
        logic [15:0] v;
        has = 1'b0;
        r   = '0;
        if (w.text_ended) begin
            r   = abort_string();
            has = 1'b1;
        end else if (dec_mode == MODE_ESC) begin
            dec_mode = MODE_PLAIN;
            case (w.code_point)
                CH_QUOTE, CH_BSLASH, CH_SLASH: hold_char(w.code_point, has, r);
                CH_B: hold_char(CH_BS, has, r);
                CH_F: hold_char(CH_FF, has, r);
                CH_N: hold_char(CH_LF, has, r);
                CH_R: hold_char(CH_CR, has, r);
                CH_T: hold_char(CH_TAB, has, r);
                CH_U: begin
                    dec_mode = MODE_HEX;
                    hex_cnt  = '0;
                    hex_acc  = '0;
                end
                default: begin
                    r   = abort_string();
                    has = 1'b1;
                end
            endcase
        end else if (dec_mode == MODE_HEX) begin
            nib = hex_nibble(w.code_point);
            if (nib < 0) begin
                r   = abort_string();
                has = 1'b1;
            end else begin
                v = {hex_acc[11:0], nib[3:0]};
                if (hex_cnt != HEX_LAST) begin
                    hex_acc = v;
                    hex_cnt = hex_cnt + 2'd1;
                end else begin
                    dec_mode = MODE_PLAIN;
                    hex_cnt  = '0;
                    hex_acc  = '0;
                    if (v[15:10] == LO_SURR_TOP && held_ok
                            && held_cp[CP_W-1:10] == HI_SURR_TOP) begin
                        held_cp = {1'b0, held_cp[9:0], v[9:0]} + SUPP_BASE;
                    end else begin
                        hold_char({5'd0, v}, has, r);
                    end
                end
            end
        end else if (w.code_point == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else if (w.code_point == CH_QUOTE) begin
            has          = 1'b1;
            r.out_char   = held_ok ? held_cp : '0;
            r.char_valid = held_ok;
            r.last       = 1'b1;
            clear_decoder();
        end else if (w.code_point < CH_SPACE) begin
            r   = abort_string();
            has = 1'b1;
        end else begin
            hold_char(w.code_point, has, r);
        end
    endfunction

    task automatic report_mismatch(input string what, input t_out_word got,
                                   input t_out_word want);
        $display("%0t MISMATCH %s: got %h/%b/%b/%b want %h/%b/%b/%b",
                 $realtime, what, got.out_char, got.char_valid, got.last, got.error,
                 want.out_char, want.char_valid, want.last, want.error);
        bad_words++;
    endtask

    task automatic check_word(input t_out_word got);
        t_out_word want;
        if (chars_due.size() == 0) begin
            report_mismatch("unexpected word", got, '0);
            return;
        end
        want = chars_due.pop_front();
        if (got.out_char !== want.out_char) report_mismatch("out_char", got, want);
        if (got.char_valid !== want.char_valid) report_mismatch("char_valid", got, want);
        if (got.last !== want.last) report_mismatch("last", got, want);
        if (got.error !== want.error) report_mismatch("error", got, want);
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) check_word(o_out_word);
            i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_word(input t_in_word w, output bit has, output t_out_word r);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_char(w, has, r);
    endtask

    task automatic drain_chars();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chars_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_dir_row mk_row(input logic [CP_W-1:0] cp, input logic ended = 1'b0,
                                        input bit typed = 1'b0,
                                        input logic [CP_W-1:0] ch = '0,
                                        input logic cv = 1'b0, input logic lst = 1'b0,
                                        input logic err = 1'b0);
        t_dir_row row;
        row.stim.code_point  = cp;
        row.stim.text_ended  = ended;
        row.typed            = typed;
        row.want.out_char    = ch;
        row.want.char_valid  = cv;
        row.want.last        = lst;
        row.want.error       = err;
        return row;
    endfunction

    function automatic void add_word(input logic [CP_W-1:0] cp, input logic ended = 1'b0);
        t_in_word w;
        w.code_point = cp;
        w.text_ended = ended;
        str_q.push_back(w);
    endfunction

    function automatic logic [CP_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return DIG_0 + n;
        return ($urandom_range(1) ? HEX_UA : HEX_LA) + (n - 4'd10);
    endfunction

    function automatic void add_hex_digits(input logic [15:0] v, input int count);
        for (int k = 0; k < count; k++) add_word(hex_char(v[15-4*k -: 4]));
    endfunction

    function automatic void add_unicode(input logic [15:0] v);
        add_word(CH_BSLASH);
        add_word(CH_U);
        add_hex_digits(v, 4);
    endfunction

    function automatic logic [CP_W-1:0] rand_plain();
        logic [CP_W-1:0] c;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: c = CP_W'($urandom_range(32, 126));
            6, 7:             c = CP_W'($urandom_range(128, 21'h10FFFF));
            default:          c = CP_W'($urandom_range(21'h110000, 21'h1FFFFF));
        endcase
        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
        return c;
    endfunction

    function automatic logic [CP_W-1:0] rand_any();
        return $urandom_range(1) ? CP_W'($urandom_range(0, 127))
                                 : CP_W'($urandom_range(0, 21'h1FFFFF));
    endfunction

    function automatic void build_string();
        int unsigned     len;
        logic [CP_W-1:0] c;
        str_q.delete();
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: add_word(rand_plain());
                9, 10, 11, 12: begin
                    add_word(CH_BSLASH);
                    case ($urandom_range(7))
                        0: add_word(CH_QUOTE);
                        1: add_word(CH_BSLASH);
                        2: add_word(CH_SLASH);
                        3: add_word(CH_B);
                        4: add_word(CH_F);
                        5: add_word(CH_N);
                        6: add_word(CH_R);
                        default: add_word(CH_T);
                    endcase
                end
                13, 14, 15: add_unicode(16'($urandom_range(0, 16'hFFFF)));
                16, 17, 18: begin
                    add_unicode(16'($urandom_range(16'hD800, 16'hDBFF)));
                    add_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                default: add_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
            endcase
        end
        if ($urandom_range(99) < 80) begin
            add_word(CH_QUOTE);
        end else begin
            case ($urandom_range(3))
                0: add_word(CP_W'($urandom_range(0, 31)));
                1: begin
                    add_word(CH_BSLASH);
                    do c = rand_any();
                    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_B
                           || c == CH_F || c == CH_N || c == CH_R || c == CH_T
                           || c == CH_U);
                    add_word(c);
                end
                2: begin
                    add_word(CH_BSLASH);
                    add_word(CH_U);
                    add_hex_digits(16'($urandom_range(0, 16'hFFFF)),
                                   int'($urandom_range(0, 3)));
                    do c = rand_any();
                    while (hex_nibble(c) >= 0);
                    add_word(c);
                end
                default: begin
                    case ($urandom_range(2))
                        0: ;
                        1: add_word(CH_BSLASH);
                        default: begin
                            add_word(CH_BSLASH);
                            add_word(CH_U);
                            add_hex_digits(16'($urandom_range(0, 16'hFFFF)),
                                           int'($urandom_range(0, 3)));
                        end
                    endcase
                    add_word(CP_W'($urandom_range(0, 21'h1FFFFF)), 1'b1);
                end
            endcase
        end
    endfunction

    initial begin
        bit        has;
        t_out_word r;
        bit        pressed;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in_word  = '0;
        bad_words  = 0;
        words_sent = 0;
        no_idle    = 1'b0;
        pressed    = 1'b0;
        clear_decoder();

        dir_rows.push_back(mk_row(CH_QUOTE, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(21'h1FFFFF, 1'b1, 1'b1, '0, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CH_SPACE));
        dir_rows.push_back(mk_row(21'h1FFFFF, 1'b0, 1'b1, CH_SPACE, 1'b1, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(CH_BSLASH));
        dir_rows.push_back(mk_row(CH_N, 1'b0, 1'b1, 21'h1FFFFF, 1'b1, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(CH_BSLASH));
        dir_rows.push_back(mk_row(CH_U));
        dir_rows.push_back(mk_row(HEX_UA + 21'd3));
        dir_rows.push_back(mk_row(DIG_0 + 21'd8));
        dir_rows.push_back(mk_row(DIG_0 + 21'd3));
        dir_rows.push_back(mk_row(HEX_LA + 21'd3, 1'b0, 1'b1, CH_LF, 1'b1, 1'b0, 1'b0));
        dir_rows.push_back(mk_row(CH_BSLASH));
        dir_rows.push_back(mk_row(CH_U));
        dir_rows.push_back(mk_row(HEX_LA + 21'd3));
        dir_rows.push_back(mk_row(HEX_UA + 21'd4));
        dir_rows.push_back(mk_row(DIG_0));
        dir_rows.push_back(mk_row(DIG_0));
        dir_rows.push_back(mk_row(CH_QUOTE, 1'b0, 1'b1, 21'h01F600, 1'b1, 1'b1, 1'b0));
        dir_rows.push_back(mk_row(CH_SPACE - 21'd1, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CH_BSLASH));
        dir_rows.push_back(mk_row(CH_X, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(mk_row(CH_BSLASH));
        dir_rows.push_back(mk_row(CH_U));
        dir_rows.push_back(mk_row(HEX_LF + 21'd1, 1'b0, 1'b1, '0, 1'b0, 1'b1, 1'b1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].stim, has, r);
            if (dir_rows[i].typed) chars_due.push_back(dir_rows[i].want);
            else if (has) chars_due.push_back(r);
        end
        drain_chars();

        while (words_sent < RANDOM_WORDS) begin
            build_string();
            no_idle = (words_sent >= 150 && words_sent < 250);
            foreach (str_q[i]) begin
                send_word(str_q[i], has, r);
                if (has) chars_due.push_back(r);
                words_sent++;
            end
            if (!pressed && words_sent >= 300) begin
                pressed = 1'b1;
                drain_chars();
            end
        end
        no_idle = 1'b0;

        drain_chars();
        repeat (10) @(posedge i_clk);
        if (bad_words == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
